>>> rtl/bhc_pkg.sv
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types, constants and commutation tables for the hall commutator.
// ----------------------------------------------------------------------------
package bhc_pkg;

  localparam int ADC_BITS = 12;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = ADC_BITS + DATA_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [DATA_W-1:0] LOW_GUARD = DATA_W'(3);

  localparam logic [1:0] OP_HALL     = 2'd0;
  localparam logic [1:0] OP_THROTTLE = 2'd1;
  localparam logic [1:0] OP_STOP     = 2'd2;

  localparam logic [1:0] SPIN_STOP = 2'd0;
  localparam logic [1:0] SPIN_CW   = 2'd1;
  localparam logic [1:0] SPIN_CCW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SPIN_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  hall_code;
    logic [11:0] throttle_sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] u_high_compare;
    logic [15:0] v_high_compare;
    logic [15:0] w_high_compare;
    logic        u_low_pin;
    logic        v_low_pin;
    logic        w_low_pin;
    logic [15:0] drive_width_out;
    logic [15:0] hall_event_count;
  } out_item_t;

  // bridge pattern bits 5..0: UH UL VH VL WH WL
  function automatic logic [5:0] fwd_pattern(input logic [2:0] code);
    logic [5:0] p;
    case (code)
      3'd1:    p = 6'h12;
      3'd2:    p = 6'h09;
      3'd3:    p = 6'h18;
      3'd4:    p = 6'h24;
      3'd5:    p = 6'h06;
      3'd6:    p = 6'h21;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

  function automatic logic [5:0] bwd_pattern(input logic [2:0] code);
    logic [5:0] p;
    case (code)
      3'd1:    p = 6'h21;
      3'd2:    p = 6'h06;
      3'd3:    p = 6'h24;
      3'd4:    p = 6'h18;
      3'd5:    p = 6'h09;
      3'd6:    p = 6'h12;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/bhc_mul.sv
// ----------------------------------------------------------------------------
// bhc_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bhc_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bhc_pkg::DATA_W-1:0]    mcand,
  input  logic [bhc_pkg::ADC_BITS-1:0]  mplier,
  output logic                          done,
  output logic [bhc_pkg::PROD_W-1:0]    product
);
  import bhc_pkg::*;

  localparam int CNT_W = $clog2(ADC_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   mcand_r, mcand_nxt;
  logic [DATA_W-1:0]   hi_r, hi_nxt;
  logic [ADC_BITS-1:0] lo_r, lo_nxt;
  logic [DATA_W:0]     sum;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    sum       = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      mcand_nxt = mcand;
      hi_nxt    = '0;
      lo_nxt    = mplier;
    end else if (busy_r) begin
      hi_nxt = sum[DATA_W:1];
      lo_nxt = {sum[0], lo_r[ADC_BITS-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ADC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule

>>> rtl/bhc_div.sv
// ----------------------------------------------------------------------------
// bhc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bhc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bhc_pkg::PROD_W-1:0]    dividend,
  input  logic [bhc_pkg::ADC_BITS-1:0]  divisor,
  output logic                          done,
  output logic [bhc_pkg::PROD_W-1:0]    quotient
);
  import bhc_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADC_BITS-1:0] div_r, div_nxt;
  logic [ADC_BITS-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0]   quo_r, quo_nxt;
  logic [ADC_BITS:0]   trial;
  logic [ADC_BITS:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[PROD_W-1]};
    diff     = trial - {1'b0, div_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      div_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[ADC_BITS-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ADC_BITS-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/bldc_hall_commutator.sv
// ----------------------------------------------------------------------------
// bldc_hall_commutator
// A hall event, stop or other request goes from S_IDLE to S_EMIT; a throttle
// sample in the scaling range passes S_MUL (ADC_BITS serial multiply steps)
// and S_DIV (ADC_BITS+16 serial divide steps) first. Throughput: one request
// at a time; the next is taken once the result is in the output register.
// Synchronous reset restores all state but out_data_r and the mul/div data.
// ----------------------------------------------------------------------------
module bldc_hall_commutator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bhc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bhc_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [bhc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);
  import bhc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_EMIT} state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          spin_r, spin_nxt;
  logic                dir_r, dir_nxt;
  logic [ADC_BITS-1:0] stop_lvl_r, stop_lvl_nxt;
  logic [ADC_BITS-1:0] start_lvl_r, start_lvl_nxt;
  logic [ADC_BITS-1:0] max_lvl_r, max_lvl_nxt;
  logic [DATA_W-1:0]   fs_r, fs_nxt;
  logic [5:0]          pat_r, pat_nxt;
  logic [DATA_W-1:0]   hc_r [3];
  logic [DATA_W-1:0]   hc_nxt [3];
  logic [2:0]          pins_r, pins_nxt;
  logic [DATA_W-1:0]   dw_r, dw_nxt;
  logic [DATA_W-1:0]   evt_r, evt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                accept;
  logic                mul_start;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;
  logic                div_done;
  logic [PROD_W-1:0]   div_quo;
  logic [ADC_BITS-1:0] sample;
  logic [ADC_BITS-1:0] sample_off;
  logic [ADC_BITS-1:0] span;
  logic [DATA_W:0]     fs_inc;
  logic [DATA_W-1:0]   fs_sat;
  logic [DATA_W-1:0]   quo_sat;
  logic                allow_fwd;
  logic                allow_bwd;

  assign sample     = ADC_BITS'(in_data.throttle_sample);
  assign sample_off = sample - stop_lvl_r;
  assign span       = max_lvl_r - start_lvl_r;
  assign fs_inc     = {1'b0, fs_r} + 1'b1;
  assign fs_sat     = fs_inc[DATA_W] ? '1 : fs_inc[DATA_W-1:0];
  assign quo_sat    = (|div_quo[PROD_W-1:DATA_W]) ? '1 : div_quo[DATA_W-1:0];
  assign allow_fwd  = (spin_r == SPIN_CW || spin_r == SPIN_STOP) && !dir_r;
  assign allow_bwd  = (spin_r == SPIN_CCW || spin_r == SPIN_STOP) && dir_r;
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;

  bhc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (fs_r),
    .mplier  (sample_off),
    .done    (mul_done),
    .product (mul_prod)
  );

  bhc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_done),
    .dividend (mul_prod),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    spin_nxt      = spin_r;
    dir_nxt       = dir_r;
    stop_lvl_nxt  = stop_lvl_r;
    start_lvl_nxt = start_lvl_r;
    max_lvl_nxt   = max_lvl_r;
    fs_nxt        = fs_r;
    pat_nxt       = pat_r;
    hc_nxt        = hc_r;
    pins_nxt      = pins_r;
    dw_nxt        = dw_r;
    evt_nxt       = evt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_SPIN_MODE:   spin_nxt      = cfg_data[1:0];
        REG_DIRECTION:   dir_nxt       = cfg_data[0];
        REG_STOP_LEVEL:  stop_lvl_nxt  = cfg_data[ADC_BITS-1:0];
        REG_START_LEVEL: start_lvl_nxt = cfg_data[ADC_BITS-1:0];
        REG_MAX_LEVEL:   max_lvl_nxt   = cfg_data[ADC_BITS-1:0];
        REG_FULL_SCALE:  fs_nxt        = cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EMIT;
          case (in_data.op)
            OP_HALL: begin
              if (allow_fwd) begin
                pat_nxt = fwd_pattern(in_data.hall_code);
              end else if (allow_bwd) begin
                pat_nxt = bwd_pattern(in_data.hall_code);
              end
              for (int ph = 0; ph < 3; ph++) begin
                if (!pat_nxt[5-2*ph]) hc_nxt[ph] = '0;
                if (!pat_nxt[4-2*ph]) pins_nxt[2-ph] = 1'b1;
                if (pat_nxt[5-2*ph] && !pat_nxt[4-2*ph] && !pat_r[5-2*ph]) begin
                  hc_nxt[ph] = dw_r;
                end
                if (pat_nxt[4-2*ph] && !pat_nxt[5-2*ph] && !pat_r[4-2*ph]) begin
                  pins_nxt[2-ph] = 1'b0;
                end
              end
              evt_nxt = evt_r + 1'b1;
            end
            OP_THROTTLE: begin
              if (sample < stop_lvl_r) begin
                dw_nxt = '0;
              end else if (sample > max_lvl_r || max_lvl_r <= start_lvl_r) begin
                dw_nxt = fs_sat;
              end else begin
                mul_start = 1'b1;
                state_nxt = S_MUL;
              end
            end
            OP_STOP: dw_nxt = DATA_W'(1);
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          dw_nxt    = (quo_sat > LOW_GUARD) ? quo_sat - LOW_GUARD : '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.u_high_compare   = hc_r[0];
          out_data_nxt.v_high_compare   = hc_r[1];
          out_data_nxt.w_high_compare   = hc_r[2];
          out_data_nxt.u_low_pin        = pins_r[2];
          out_data_nxt.v_low_pin        = pins_r[1];
          out_data_nxt.w_low_pin        = pins_r[0];
          out_data_nxt.drive_width_out  = dw_r;
          out_data_nxt.hall_event_count = evt_r;
          state_nxt                     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spin_r      <= SPIN_STOP;
      dir_r       <= 1'b0;
      stop_lvl_r  <= '0;
      start_lvl_r <= '0;
      max_lvl_r   <= '1;
      fs_r        <= '0;
      pat_r       <= '0;
      hc_r[0]     <= '0;
      hc_r[1]     <= '0;
      hc_r[2]     <= '0;
      pins_r      <= '1;
      dw_r        <= '0;
      evt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spin_r      <= spin_nxt;
      dir_r       <= dir_nxt;
      stop_lvl_r  <= stop_lvl_nxt;
      start_lvl_r <= start_lvl_nxt;
      max_lvl_r   <= max_lvl_nxt;
      fs_r        <= fs_nxt;
      pat_r       <= pat_nxt;
      hc_r        <= hc_nxt;
      pins_r      <= pins_nxt;
      dw_r        <= dw_nxt;
      evt_r       <= evt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/bhc_drive_checker.sv
// ----------------------------------------------------------------------------
// bhc_drive_checker
// Watches the request, result and register ports of the hall commutator,
// predicts the bridge drive state for every accepted request and compares
// each delivered result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bhc_drive_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  bhc_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  bhc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [bhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            mismatch_count,
  output int                            outstanding
);
  import bhc_pkg::*;

  // six-bit rows UH UL VH VL WH WL, hall code 7 first
  localparam logic [47:0] FWD_ROWS = {6'h00, 6'h21, 6'h06, 6'h24, 6'h18, 6'h09, 6'h12, 6'h00};
  localparam logic [47:0] BWD_ROWS = {6'h00, 6'h12, 6'h09, 6'h18, 6'h24, 6'h06, 6'h21, 6'h00};

  logic [1:0]  spin_mode;
  logic        rev_dir;
  logic [11:0] stop_lvl;
  logic [11:0] start_lvl;
  logic [11:0] max_lvl;
  logic [15:0] full_scale;

  logic [5:0]  bridge;
  logic [15:0] hi_cmp [3];
  logic [2:0]  lo_pins;
  logic [15:0] width;
  logic [15:0] hall_count;

  out_item_t   predicted_drive_q [$];

  function automatic logic [15:0] scale_throttle(input logic [11:0] s);
    logic [31:0] q;
    if (s < stop_lvl) return '0;
    if (s > max_lvl || max_lvl <= start_lvl)
      return (full_scale == 16'hFFFF) ? 16'hFFFF : full_scale + 16'd1;
    q = (32'(s) - 32'(stop_lvl)) * 32'(full_scale) / (32'(max_lvl) - 32'(start_lvl));
    if (q > 32'hFFFF) q = 32'hFFFF;
    return (q[15:0] > LOW_GUARD) ? q[15:0] - LOW_GUARD : '0;
  endfunction

  task automatic hall_event(input logic [2:0] code);
    logic [5:0] prev;
    int hs;
    prev = bridge;
    if ((spin_mode == SPIN_CW || spin_mode == SPIN_STOP) && !rev_dir)
      bridge = FWD_ROWS[code*6 +: 6];
    else if ((spin_mode == SPIN_CCW || spin_mode == SPIN_STOP) && rev_dir)
      bridge = BWD_ROWS[code*6 +: 6];
    for (int ph = 0; ph < 3; ph++) begin
      hs = 5 - 2 * ph;
      if (!bridge[hs]) hi_cmp[ph] = '0;
      if (!bridge[hs-1]) lo_pins[2-ph] = 1'b1;
      if (bridge[hs] && !bridge[hs-1] && !prev[hs]) hi_cmp[ph] = width;
      if (bridge[hs-1] && !bridge[hs] && !prev[hs-1]) lo_pins[2-ph] = 1'b0;
    end
    hall_count = hall_count + 16'd1;
  endtask

  task automatic apply_request(input in_item_t req);
    out_item_t snap;
    case (req.op)
      OP_HALL:     hall_event(req.hall_code);
      OP_THROTTLE: width = scale_throttle(req.throttle_sample);
      OP_STOP:     width = 16'd1;
      default:     ;
    endcase
    snap.u_high_compare   = hi_cmp[0];
    snap.v_high_compare   = hi_cmp[1];
    snap.w_high_compare   = hi_cmp[2];
    snap.u_low_pin        = lo_pins[2];
    snap.v_low_pin        = lo_pins[1];
    snap.w_low_pin        = lo_pins[0];
    snap.drive_width_out  = width;
    snap.hall_event_count = hall_count;
    predicted_drive_q.push_back(snap);
  endtask

  function automatic string drive_str(input out_item_t d);
    return $sformatf("u=%0d v=%0d w=%0d pins=%b%b%b width=%0d halls=%0d",
                     d.u_high_compare, d.v_high_compare, d.w_high_compare,
                     d.u_low_pin, d.v_low_pin, d.w_low_pin,
                     d.drive_width_out, d.hall_event_count);
  endfunction

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    logic bad;
    if (predicted_drive_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] unexpected result: %s", $time, drive_str(got));
      return;
    end
    want = predicted_drive_q.pop_front();
    bad = (got.u_high_compare   !== want.u_high_compare)
       || (got.v_high_compare   !== want.v_high_compare)
       || (got.w_high_compare   !== want.w_high_compare)
       || (got.u_low_pin        !== want.u_low_pin)
       || (got.v_low_pin        !== want.v_low_pin)
       || (got.w_low_pin        !== want.w_low_pin)
       || (got.drive_width_out  !== want.drive_width_out)
       || (got.hall_event_count !== want.hall_event_count);
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] drive state differs\n  expected %s\n  actual   %s",
                 $time, drive_str(want), drive_str(got));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      spin_mode  = SPIN_STOP;
      rev_dir    = 1'b0;
      stop_lvl   = '0;
      start_lvl  = '0;
      max_lvl    = 12'hFFF;
      full_scale = '0;
      bridge     = '0;
      for (int ph = 0; ph < 3; ph++) hi_cmp[ph] = '0;
      lo_pins    = 3'b111;
      width      = '0;
      hall_count = '0;
      predicted_drive_q.delete();
    end else begin
      if (out_valid && out_ready) compare_result(out_data);
      if (in_valid && in_ready) apply_request(in_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_SPIN_MODE:   spin_mode  = cfg_data[1:0];
          REG_DIRECTION:   rev_dir    = cfg_data[0];
          REG_STOP_LEVEL:  stop_lvl   = cfg_data[11:0];
          REG_START_LEVEL: start_lvl  = cfg_data[11:0];
          REG_MAX_LEVEL:   max_lvl    = cfg_data[11:0];
          REG_FULL_SCALE:  full_scale = cfg_data;
          default:         ;
        endcase
      end
    end
    outstanding = predicted_drive_q.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives hall events, throttle samples, stop and no-op requests into the
// commutator under a series of register settings, with random gaps on the
// request side and random stalls on the result side; the drive checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import bhc_pkg::*;

  localparam logic [1:0] OP_NOP        = 2'd3;
  localparam logic [1:0] SPIN_DISABLED = 2'd3;
  localparam int         LIMIT         = 1_000_000;
  localparam int         PHASES        = 10;
  localparam int         RANDOM_ITEMS  = 1000;
  // rotation order 1 3 2 6 4 5, first entry in the low bits
  localparam logic [17:0] HALL_SEQ = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  int          mismatches;
  int          outstanding;
  int          cycles    = 0;
  int          rdy_hold  = 0;
  int          hall_pos  = 0;
  int          hall_step = 1;
  bit          quiet     = 1'b0;
  logic [11:0] lvl_stop  = '0;
  logic [11:0] lvl_start = '0;
  logic [11:0] lvl_max   = 12'hFFF;

  bldc_hall_commutator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bhc_drive_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .outstanding    (outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side stalls
  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if ($urandom_range(0, 99) < 5) begin
      out_ready <= 1'b1;
      rdy_hold  <= $urandom_range(200, 400);
    end else if ($urandom_range(0, 9) < 6) begin
      out_ready <= 1'b1;
      rdy_hold  <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b0;
      rdy_hold  <= idle_cycles();
    end
  end

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send(input logic [1:0] op, input logic [2:0] code, input logic [11:0] sample);
    in_item_t req;
    req.op              = op;
    req.hall_code       = code;
    req.throttle_sample = sample;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet) pause(idle_cycles());
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [1:0] spin, input logic dir,
                            input logic [11:0] stop_l, input logic [11:0] start_l,
                            input logic [11:0] max_l, input logic [15:0] fs);
    drain();
    write_reg(REG_SPIN_MODE, 16'(spin));
    write_reg(REG_DIRECTION, 16'(dir));
    write_reg(REG_STOP_LEVEL, 16'(stop_l));
    write_reg(REG_START_LEVEL, 16'(start_l));
    write_reg(REG_MAX_LEVEL, 16'(max_l));
    write_reg(REG_FULL_SCALE, fs);
    lvl_stop  = stop_l;
    lvl_start = start_l;
    lvl_max   = max_l;
  endtask

  task automatic random_setup();
    logic [1:0]  spin;
    logic        dir;
    logic [11:0] stop_l;
    logic [11:0] start_l;
    logic [11:0] max_l;
    logic [15:0] fs;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 30) spin = SPIN_CW;
    else if (r < 60) spin = SPIN_CCW;
    else if (r < 85) spin = SPIN_STOP;
    else spin = SPIN_DISABLED;
    if ($urandom_range(0, 3) != 0) dir = (spin == SPIN_CCW);
    else dir = 1'($urandom_range(0, 1));
    stop_l  = 12'($urandom_range(0, 1500));
    start_l = 12'($urandom_range(0, 1000));
    max_l   = 12'($urandom_range(2000, 4095));
    if ($urandom_range(0, 7) == 0) max_l = 12'($urandom_range(0, start_l));
    r = $urandom_range(0, 99);
    if (r < 10) fs = 16'h0000;
    else if (r < 20) fs = 16'hFFFF;
    else if (r < 30) fs = 16'hFFFE;
    else fs = 16'($urandom_range(100, 65535));
    set_config(spin, dir, stop_l, start_l, max_l, fs);
  endtask

  function automatic logic [2:0] next_hall();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 85) return 3'($urandom_range(0, 7));
    if (r < 75) hall_pos = (hall_pos + hall_step) % 6;
    return HALL_SEQ[hall_pos*3 +: 3];
  endfunction

  function automatic logic [11:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 12'(int'(lvl_stop) + $urandom_range(0, 4) - 2);
    if (r < 25) return 12'(int'(lvl_start) + $urandom_range(0, 4) - 2);
    if (r < 40) return 12'(int'(lvl_max) + $urandom_range(0, 4) - 2);
    if (r < 45) return 12'h000;
    if (r < 50) return 12'hFFF;
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) send(OP_HALL, next_hall(), 12'($urandom_range(0, 4095)));
    else if (r < 88) send(OP_THROTTLE, 3'($urandom_range(0, 7)), pick_sample());
    else if (r < 94) send(OP_STOP, 3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)));
    else send(OP_NOP, 3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // settings straight out of reset
    send(OP_HALL, 3'd1, 12'h000);
    send(OP_THROTTLE, 3'd0, 12'hFFF);

    set_config(SPIN_CW, 1'b0, 12'd100, 12'd50, 12'd3000, 16'd20000);
    send(OP_THROTTLE, 3'd0, 12'd2000);
    for (int i = 0; i < 6; i++) send(OP_HALL, HALL_SEQ[i*3 +: 3], 12'd0);
    send(OP_HALL, 3'd7, 12'hFFF);
    send(OP_HALL, 3'd0, 12'd0);
    send(OP_THROTTLE, 3'd7, 12'd99);
    send(OP_THROTTLE, 3'd0, 12'd100);
    send(OP_THROTTLE, 3'd0, 12'd101);
    send(OP_THROTTLE, 3'd0, 12'd3001);
    send(OP_STOP, 3'd5, 12'hFFF);
    send(OP_HALL, 3'd4, 12'd0);
    send(OP_NOP, 3'd7, 12'hAAA);

    // spin disabled, inverted span, full scale overflow
    set_config(SPIN_DISABLED, 1'b1, 12'hFFF, 12'hFFF, 12'h000, 16'hFFFF);
    send(OP_HALL, 3'd2, 12'd0);
    send(OP_THROTTLE, 3'd0, 12'hFFF);
    send(OP_THROTTLE, 3'd0, 12'h000);

    // counter-clockwise backward table, then forward table refused
    set_config(SPIN_CCW, 1'b1, 12'd0, 12'd0, 12'hFFF, 16'hFFFE);
    send(OP_THROTTLE, 3'd0, 12'hFFF);
    send(OP_HALL, 3'd1, 12'd0);
    send(OP_HALL, 3'd3, 12'd0);
    drain();
    write_reg(REG_DIRECTION, 16'd0);
    send(OP_HALL, 3'd2, 12'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      random_setup();
      hall_step = ($urandom_range(0, 1) != 0) ? 1 : 5;
      quiet     = (ph % 4 == 3);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        random_request();
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    repeat (60) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
